// File: sv/iepf_pkg.sv
// shared types and constants for the icmp echo packet filter
// no dependencies; used by iepf_parser and icmp_echo_packet_filter_top

package iepf_pkg;

  localparam int MAX_TAG_DEPTH = 2;

  localparam logic [15:0] TPID_CTAG = 16'h8100;
  localparam logic [15:0] TPID_STAG = 16'h88A8;
  localparam logic [15:0] ETYPE_IP6 = 16'h86DD;
  localparam logic [15:0] ETYPE_IP4 = 16'h0800;

  localparam logic [7:0] PROTO_ICMP6    = 8'd58;
  localparam logic [7:0] PROTO_ICMP4    = 8'd1;
  localparam logic [7:0] ICMP6_ECHO_REQ = 8'd128;
  localparam logic [7:0] ICMP4_ECHO_REQ = 8'd8;

  // byte positions inside the headers
  localparam logic [6:0] ETH_TYPE_HI_OFF = 7'd12;
  localparam logic [6:0] ETH_TYPE_LO_OFF = 7'd13;
  localparam logic [6:0] TAG_TYPE_HI_REL = 7'd2;
  localparam logic [6:0] TAG_TYPE_LO_REL = 7'd3;
  localparam logic [6:0] IPV4_PROTO_REL  = 7'd9;
  localparam logic [6:0] IPV6_NEXT_REL   = 7'd6;
  localparam logic [6:0] IPV6_LAST_REL   = 7'd39;
  localparam logic [6:0] ICMP_TYPE_REL   = 7'd0;
  localparam logic [6:0] ICMP_SEQ_LO_REL = 7'd7;
  localparam logic [6:0] OFFSET_MAX      = 7'd127;
  localparam logic [3:0] IHL_MIN         = 4'd5;

  typedef enum logic [2:0] {
    PH_ETH  = 3'd0,
    PH_TAG  = 3'd1,
    PH_IPV4 = 3'd2,
    PH_IPV6 = 3'd3,
    PH_ICMP = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  // one byte moving from the input register into the parser
  typedef struct packed {
    logic       adv;
    logic [7:0] data;
    logic       last;
  } step_t;

endpackage

// File: sv/iepf_parser.sv
// header parser: per-packet state and its next-state logic, one byte per cycle while step.adv is high
// depends on iepf_pkg

module iepf_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  iepf_pkg::step_t step,
  output logic           drop
);

  logic [6:0]       byte_offset_r, byte_offset_nxt;
  iepf_pkg::phase_t phase_r, phase_nxt;
  logic [6:0]       header_start_r, header_start_nxt;
  logic [15:0]      ether_type_r, ether_type_nxt;
  logic [1:0]       tag_count_r, tag_count_nxt;
  logic [3:0]       ihl_r, ihl_nxt;
  logic [7:0]       next_proto_r, next_proto_nxt;
  logic             echo_match_r, echo_match_nxt;
  logic             drop_pending_r, drop_pending_nxt;

  logic [6:0] rel;
  logic [6:0] ipv4_last_rel;

  // phase that follows the link layer or a tag
  function automatic iepf_pkg::phase_t link_phase(input logic [15:0] et,
                                                  input logic [1:0]  tags);
    iepf_pkg::phase_t ph;
    if ((et == iepf_pkg::TPID_CTAG || et == iepf_pkg::TPID_STAG) &&
        tags < 2'(iepf_pkg::MAX_TAG_DEPTH)) begin
      ph = iepf_pkg::PH_TAG;
    end else if (et == iepf_pkg::ETYPE_IP6) begin
      ph = iepf_pkg::PH_IPV6;
    end else if (et == iepf_pkg::ETYPE_IP4) begin
      ph = iepf_pkg::PH_IPV4;
    end else begin
      ph = iepf_pkg::PH_DONE;
    end
    return ph;
  endfunction

  assign rel           = byte_offset_r - header_start_r;
  assign ipv4_last_rel = {1'b0, ihl_r, 2'b00} - 7'd1;

  always_comb begin
    phase_nxt        = phase_r;
    header_start_nxt = header_start_r;
    ether_type_nxt   = ether_type_r;
    tag_count_nxt    = tag_count_r;
    ihl_nxt          = ihl_r;
    next_proto_nxt   = next_proto_r;
    echo_match_nxt   = echo_match_r;
    drop_pending_nxt = drop_pending_r;

    case (phase_r)
      iepf_pkg::PH_ETH: begin
        if (byte_offset_r == iepf_pkg::ETH_TYPE_HI_OFF) begin
          ether_type_nxt = {step.data, ether_type_r[7:0]};
        end else if (byte_offset_r == iepf_pkg::ETH_TYPE_LO_OFF) begin
          ether_type_nxt   = {ether_type_r[15:8], step.data};
          header_start_nxt = byte_offset_r + 7'd1;
          phase_nxt        = link_phase(ether_type_nxt, tag_count_r);
        end
      end
      iepf_pkg::PH_TAG: begin
        if (rel == iepf_pkg::TAG_TYPE_HI_REL) begin
          ether_type_nxt = {step.data, ether_type_r[7:0]};
        end else if (rel == iepf_pkg::TAG_TYPE_LO_REL) begin
          ether_type_nxt   = {ether_type_r[15:8], step.data};
          tag_count_nxt    = tag_count_r + 2'd1;
          header_start_nxt = byte_offset_r + 7'd1;
          phase_nxt        = link_phase(ether_type_nxt, tag_count_nxt);
        end
      end
      iepf_pkg::PH_IPV4: begin
        if (rel == 7'd0) begin
          ihl_nxt = step.data[3:0];
          if (ihl_nxt < iepf_pkg::IHL_MIN) begin
            phase_nxt = iepf_pkg::PH_DONE;
          end
        end else begin
          if (rel == iepf_pkg::IPV4_PROTO_REL) begin
            next_proto_nxt = step.data;
          end
          if (rel == ipv4_last_rel) begin
            if (next_proto_nxt == iepf_pkg::PROTO_ICMP4) begin
              phase_nxt        = iepf_pkg::PH_ICMP;
              header_start_nxt = byte_offset_r + 7'd1;
            end else begin
              phase_nxt = iepf_pkg::PH_DONE;
            end
          end
        end
      end
      iepf_pkg::PH_IPV6: begin
        if (rel == iepf_pkg::IPV6_NEXT_REL) begin
          next_proto_nxt = step.data;
        end
        if (rel == iepf_pkg::IPV6_LAST_REL) begin
          if (next_proto_nxt == iepf_pkg::PROTO_ICMP6) begin
            phase_nxt        = iepf_pkg::PH_ICMP;
            header_start_nxt = byte_offset_r + 7'd1;
          end else begin
            phase_nxt = iepf_pkg::PH_DONE;
          end
        end
      end
      iepf_pkg::PH_ICMP: begin
        if (rel == iepf_pkg::ICMP_TYPE_REL) begin
          if (ether_type_r == iepf_pkg::ETYPE_IP6) begin
            echo_match_nxt = (step.data == iepf_pkg::ICMP6_ECHO_REQ);
          end else begin
            echo_match_nxt = (step.data == iepf_pkg::ICMP4_ECHO_REQ);
          end
          if (!echo_match_nxt) begin
            phase_nxt = iepf_pkg::PH_DONE;
          end
        end else if (rel == iepf_pkg::ICMP_SEQ_LO_REL) begin
          // even sequence number: low bit of the second sequence byte
          drop_pending_nxt = echo_match_r && !step.data[0];
          phase_nxt        = iepf_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (byte_offset_r != iepf_pkg::OFFSET_MAX) begin
      byte_offset_nxt = byte_offset_r + 7'd1;
    end else begin
      byte_offset_nxt = byte_offset_r;
    end
  end

  // verdict of the packet as it stands after this byte
  assign drop = drop_pending_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (step.adv && step.last)) begin
      byte_offset_r  <= '0;
      phase_r        <= iepf_pkg::PH_ETH;
      header_start_r <= '0;
      ether_type_r   <= '0;
      tag_count_r    <= '0;
      ihl_r          <= '0;
      next_proto_r   <= '0;
      echo_match_r   <= 1'b0;
      drop_pending_r <= 1'b0;
    end else if (step.adv) begin
      byte_offset_r  <= byte_offset_nxt;
      phase_r        <= phase_nxt;
      header_start_r <= header_start_nxt;
      ether_type_r   <= ether_type_nxt;
      tag_count_r    <= tag_count_nxt;
      ihl_r          <= ihl_nxt;
      next_proto_r   <= next_proto_nxt;
      echo_match_r   <= echo_match_nxt;
      drop_pending_r <= drop_pending_nxt;
    end
  end

endmodule

// File: sv/icmp_echo_packet_filter_top.sv
// icmp echo packet filter: input register, header parser, verdict register
// depends on iepf_pkg and iepf_parser
//
// Usage:
//   Packet bytes enter on in_data_byte in wire order, in_last_byte marks the
//   final byte. A transaction completes on a clock edge with in_valid high and
//   in_stall low. One byte can be taken every cycle while in_stall stays low.
//   For each packet one verdict leaves on out_action (0 pass, 1 drop) with
//   out_valid; it completes when out_stall is low. Bytes other than the last
//   produce no output transaction.
//   A byte is registered in the input register when it is accepted and parsed
//   from there; the verdict of a last byte is written into the output register
//   when that byte advances, and out_valid rises with that write.
//   The parser takes one byte per cycle unless a last byte is held back.
//   When the receiver stalls, the held verdict stays put; further non-last
//   bytes still flow, and in_stall rises only when a last byte waits for the
//   full output register.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the start of a packet.

module icmp_echo_packet_filter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_action
);

  logic       in_valid_r;
  logic [7:0] in_data_r;
  logic       in_last_r;
  logic       out_valid_r;
  logic       out_action_r;

  logic            out_free;
  logic            adv;
  logic            drop;
  iepf_pkg::step_t step;

  assign out_free = !out_valid_r || !out_stall;
  // non-last bytes never need the output register
  assign adv      = in_valid_r && (!in_last_r || out_free);
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  assign step.adv  = adv;
  assign step.data = in_data_r;
  assign step.last = in_last_r;

  iepf_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .drop  (drop)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_r) begin
      out_action_r <= drop;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;

  // a parsed last byte always lands in the output register
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |=> out_valid_r)
    else $error("last byte advanced without a verdict");

  // a new verdict appears only from a parsed last byte
  a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && in_last_r))
    else $error("verdict without a last byte");

  // the input side stalls only behind a last byte blocked by a full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && in_last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked verdict");

endmodule

// File: dv/icmp_echo_packet_filter_top_tb.sv
// self-checking testbench for icmp_echo_packet_filter_top: drives whole frames byte by byte
// and checks each drop/pass verdict against the frame's given verdict or a byte-level header parse model
// depends on iepf_pkg and the filter rtl

module icmp_echo_packet_filter_top_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_COUNT  = 1250;

  // ethertype that is neither a tag nor ip
  localparam logic [15:0] ETYPE_ARP = 16'h0806;

  typedef logic [7:0] byte_q_t [$];

  // recipe of one frame; verdict is -1 when the parse model decides it
  typedef struct packed {
    int          tags;
    int          ad_mask;
    logic [15:0] l3_type;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [7:0]  icmp_type;
    logic [15:0] seq;
    int          payload;
    int          cut;
    int          verdict;
  } frame_t;

  localparam frame_t DIRECTED_FRAMES [22] = '{
    '{0, 0, iepf_pkg::ETYPE_IP4, 4'd5, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h0000, 4, 0, 1},
    '{0, 0, iepf_pkg::ETYPE_IP4, 4'd5, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'hFFFF, 4, 0, 0},
    '{0, 0, iepf_pkg::ETYPE_IP6, 4'd5, iepf_pkg::PROTO_ICMP6,
      iepf_pkg::ICMP6_ECHO_REQ, 16'hFFFE, 0, 0, 1},
    '{0, 0, iepf_pkg::ETYPE_IP6, 4'd5, iepf_pkg::PROTO_ICMP6,
      iepf_pkg::ICMP6_ECHO_REQ, 16'h0001, 0, 0, 0},
    '{0, 0, iepf_pkg::ETYPE_IP4, 4'd5, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP6_ECHO_REQ, 16'h0000, 0, 0, 0},
    '{0, 0, iepf_pkg::ETYPE_IP6, 4'd5, iepf_pkg::PROTO_ICMP6,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h0000, 0, 0, 0},
    '{0, 0, iepf_pkg::ETYPE_IP4, 4'd5, iepf_pkg::PROTO_ICMP6,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h0000, 0, 0, 0},
    '{0, 0, iepf_pkg::ETYPE_IP6, 4'd5, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP6_ECHO_REQ, 16'h0000, 0, 0, 0},
    // ihl below the minimum
    '{0, 0, iepf_pkg::ETYPE_IP4, 4'd4, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h0000, 0, 0, 0},
    '{0, 0, iepf_pkg::ETYPE_IP4, 4'd0, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h0000, 0, 0, 0},
    '{0, 0, iepf_pkg::ETYPE_IP4, 4'd15, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h1234, 2, 0, 1},
    '{1, 0, iepf_pkg::ETYPE_IP4, 4'd5, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h0002, 0, 0, 1},
    '{2, 1, iepf_pkg::ETYPE_IP6, 4'd5, iepf_pkg::PROTO_ICMP6,
      iepf_pkg::ICMP6_ECHO_REQ, 16'h8000, 0, 0, 1},
    // one tag more than the parser skips
    '{3, 7, iepf_pkg::ETYPE_IP4, 4'd5, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h0000, 0, 0, 0},
    '{0, 0, ETYPE_ARP, 4'd5, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h0000, 0, 0, 0},
    // truncated before the low sequence byte, inside the ethernet header, one byte only
    '{0, 0, iepf_pkg::ETYPE_IP4, 4'd5, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h0000, 0, 41, 0},
    '{0, 0, iepf_pkg::ETYPE_IP4, 4'd5, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h0000, 0, 13, 0},
    '{0, 0, iepf_pkg::ETYPE_IP4, 4'd5, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h0000, 0, 1, 0},
    // long frame, offset saturates
    '{0, 0, iepf_pkg::ETYPE_IP4, 4'd5, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h0010, 120, 0, 1},
    '{2, 2, iepf_pkg::ETYPE_IP4, 4'd7, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h3C5A, 3, 0, -1},
    '{1, 1, iepf_pkg::ETYPE_IP6, 4'd5, iepf_pkg::PROTO_ICMP6,
      iepf_pkg::ICMP6_ECHO_REQ, 16'hBEEF, 0, 60, -1},
    '{1, 1, iepf_pkg::ETYPE_IP4, 4'd6, iepf_pkg::PROTO_ICMP4,
      iepf_pkg::ICMP4_ECHO_REQ, 16'h7FFE, 5, 0, -1}
  };

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic       out_action;

  icmp_echo_packet_filter_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_action  (out_action)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // header parse model state
  iepf_pkg::phase_t ph;
  logic [6:0]       at;
  logic [6:0]       hdr_at;
  logic [15:0]      eth_type;
  logic [1:0]       tags_seen;
  logic [3:0]       ihl_q;
  logic [7:0]       proto_q;
  logic             echo_q;
  logic             drop_q;

  logic due_verdicts [$];
  int   mismatches   = 0;
  int   bytes_sent   = 0;
  int   cycle_count  = 0;

  function automatic void clear_parse();
    ph        = iepf_pkg::PH_ETH;
    at        = '0;
    hdr_at    = '0;
    eth_type  = '0;
    tags_seen = '0;
    ihl_q     = '0;
    proto_q   = '0;
    echo_q    = 1'b0;
    drop_q    = 1'b0;
  endfunction

  // pick what follows the link layer, next header begins at next_at
  function automatic void enter_l3(input logic [6:0] next_at);
    hdr_at = next_at;
    if ((eth_type == iepf_pkg::TPID_CTAG || eth_type == iepf_pkg::TPID_STAG) &&
        tags_seen < iepf_pkg::MAX_TAG_DEPTH)
      ph = iepf_pkg::PH_TAG;
    else if (eth_type == iepf_pkg::ETYPE_IP6)
      ph = iepf_pkg::PH_IPV6;
    else if (eth_type == iepf_pkg::ETYPE_IP4)
      ph = iepf_pkg::PH_IPV4;
    else
      ph = iepf_pkg::PH_DONE;
  endfunction

  // returns 1 when the byte ends a frame, with its verdict
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output logic verdict);
    logic [6:0] rel;
    rel = at - hdr_at;
    verdict = 1'b0;
    case (ph)
      iepf_pkg::PH_ETH: begin
        if (at == iepf_pkg::ETH_TYPE_HI_OFF) begin
          eth_type[15:8] = b;
        end else if (at == iepf_pkg::ETH_TYPE_LO_OFF) begin
          eth_type[7:0] = b;
          enter_l3(at + 7'd1);
        end
      end
      iepf_pkg::PH_TAG: begin
        if (rel == iepf_pkg::TAG_TYPE_HI_REL) begin
          eth_type[15:8] = b;
        end else if (rel == iepf_pkg::TAG_TYPE_LO_REL) begin
          eth_type[7:0] = b;
          tags_seen = tags_seen + 2'd1;
          enter_l3(at + 7'd1);
        end
      end
      iepf_pkg::PH_IPV4: begin
        if (rel == 7'd0) begin
          ihl_q = b[3:0];
          if (ihl_q < iepf_pkg::IHL_MIN) ph = iepf_pkg::PH_DONE;
        end else begin
          if (rel == iepf_pkg::IPV4_PROTO_REL) proto_q = b;
          if (int'(rel) == 4 * int'(ihl_q) - 1) begin
            if (proto_q == iepf_pkg::PROTO_ICMP4) begin
              ph = iepf_pkg::PH_ICMP;
              hdr_at = at + 7'd1;
            end else begin
              ph = iepf_pkg::PH_DONE;
            end
          end
        end
      end
      iepf_pkg::PH_IPV6: begin
        if (rel == iepf_pkg::IPV6_NEXT_REL) proto_q = b;
        if (rel == iepf_pkg::IPV6_LAST_REL) begin
          if (proto_q == iepf_pkg::PROTO_ICMP6) begin
            ph = iepf_pkg::PH_ICMP;
            hdr_at = at + 7'd1;
          end else begin
            ph = iepf_pkg::PH_DONE;
          end
        end
      end
      iepf_pkg::PH_ICMP: begin
        if (rel == iepf_pkg::ICMP_TYPE_REL) begin
          if (eth_type == iepf_pkg::ETYPE_IP6)
            echo_q = (b == iepf_pkg::ICMP6_ECHO_REQ);
          else
            echo_q = (b == iepf_pkg::ICMP4_ECHO_REQ);
          if (!echo_q) ph = iepf_pkg::PH_DONE;
        end else if (rel == iepf_pkg::ICMP_SEQ_LO_REL) begin
          drop_q = echo_q && !b[0];
          ph = iepf_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
    if (at < iepf_pkg::OFFSET_MAX) at = at + 7'd1;
    if (last) begin
      verdict = drop_q;
      clear_parse();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void build_frame(input frame_t f, output byte_q_t pkt);
    int          hl;
    logic [15:0] tpid;
    pkt = {};
    repeat (12) pkt.push_back(8'($urandom));
    for (int t = 0; t < f.tags; t++) begin
      tpid = f.ad_mask[t] ? iepf_pkg::TPID_STAG : iepf_pkg::TPID_CTAG;
      pkt.push_back(tpid[15:8]);
      pkt.push_back(tpid[7:0]);
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
    end
    pkt.push_back(f.l3_type[15:8]);
    pkt.push_back(f.l3_type[7:0]);
    if (f.l3_type == iepf_pkg::ETYPE_IP6) begin
      pkt.push_back({4'h6, 4'($urandom)});
      for (int i = 1; i < 40; i++)
        pkt.push_back(i == iepf_pkg::IPV6_NEXT_REL ? f.proto : 8'($urandom));
    end else begin
      hl = (f.ihl < iepf_pkg::IHL_MIN) ? 20 : 4 * f.ihl;
      pkt.push_back({4'h4, f.ihl});
      for (int i = 1; i < hl; i++)
        pkt.push_back(i == iepf_pkg::IPV4_PROTO_REL ? f.proto : 8'($urandom));
    end
    pkt.push_back(f.icmp_type);
    repeat (5) pkt.push_back(8'($urandom));
    pkt.push_back(f.seq[15:8]);
    pkt.push_back(f.seq[7:0]);
    repeat (f.payload) pkt.push_back(8'($urandom));
    if (f.cut > 0)
      while (pkt.size() > f.cut) void'(pkt.pop_back());
  endfunction

  // mostly well-formed echo traffic with random content, some of it broken
  function automatic frame_t random_frame();
    frame_t f;
    int     pick;
    pick = $urandom_range(0, 9);
    f.tags = pick < 5 ? 0 : pick < 7 ? 1 : pick < 9 ? 2 : 3;
    f.ad_mask = $urandom_range(0, 7);
    pick = $urandom_range(0, 19);
    f.l3_type = pick < 9 ? iepf_pkg::ETYPE_IP4 : pick < 17 ? iepf_pkg::ETYPE_IP6
                                                          : 16'($urandom);
    f.ihl = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 4))
                                        : 4'($urandom_range(5, 15));
    if ($urandom_range(0, 6) != 0)
      f.proto = (f.l3_type == iepf_pkg::ETYPE_IP6) ? iepf_pkg::PROTO_ICMP6
                                                   : iepf_pkg::PROTO_ICMP4;
    else
      f.proto = ($urandom_range(0, 1) == 0) ? 8'($urandom)
              : (f.l3_type == iepf_pkg::ETYPE_IP6) ? iepf_pkg::PROTO_ICMP4
                                                   : iepf_pkg::PROTO_ICMP6;
    if ($urandom_range(0, 4) != 0)
      f.icmp_type = (f.l3_type == iepf_pkg::ETYPE_IP6) ? iepf_pkg::ICMP6_ECHO_REQ
                                                       : iepf_pkg::ICMP4_ECHO_REQ;
    else
      f.icmp_type = ($urandom_range(0, 1) == 0) ? 8'($urandom)
                  : (f.l3_type == iepf_pkg::ETYPE_IP6) ? iepf_pkg::ICMP4_ECHO_REQ
                                                       : iepf_pkg::ICMP6_ECHO_REQ;
    f.seq = 16'($urandom);
    f.payload = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 110) : $urandom_range(0, 12);
    f.cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 90) : 0;
    f.verdict = -1;
    return f;
  endfunction

  task automatic send_frame(input byte_q_t pkt, input int typed_verdict, input bit paced);
    int   gap;
    logic v;
    foreach (pkt[i]) begin
      gap = paced ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_data_byte <= pkt[i];
      in_last_byte <= (i == pkt.size() - 1);
      do @(posedge clk); while (in_stall !== 1'b0);
      bytes_sent++;
      if (parse_byte(pkt[i], i == pkt.size() - 1, v)) begin
        due_verdicts.push_back(typed_verdict < 0 ? v : typed_verdict[0]);
      end
    end
  endtask

  initial begin : stimulus
    byte_q_t pkt;
    frame_t  f;
    bit      paced;
    clear_parse();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_FRAMES[r]) begin
      build_frame(DIRECTED_FRAMES[r], pkt);
      send_frame(pkt, DIRECTED_FRAMES[r].verdict, $urandom_range(0, 3) != 0);
    end
    while (bytes_sent < ITEM_COUNT) begin
      paced = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) begin
        // raw noise frame
        pkt = {};
        repeat ($urandom_range(1, 60)) pkt.push_back(8'($urandom));
        send_frame(pkt, -1, paced);
      end else begin
        f = random_frame();
        build_frame(f, pkt);
        send_frame(pkt, f.verdict, paced);
      end
    end
    in_valid <= 1'b0;
    while (due_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("icmp_echo_packet_filter_top_tb OK");
    else
      $display("icmp_echo_packet_filter_top_tb NOT OK");
    $finish;
  end

  initial begin : verdict_check
    int   hold;
    bit   rx_paced;
    logic want;
    rx_paced = 1'b1;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = rx_paced ? $urandom_range(0, 7) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall == 1'b0));
      if (due_verdicts.size() == 0) begin
        if (mismatches < 10) $display("unexpected verdict transaction, action %0b", out_action);
        mismatches++;
      end else begin
        want = due_verdicts.pop_front();
        if (out_action !== want) begin
          if (mismatches < 10)
            $display("verdict mismatch: expected %0b, got %0b", want, out_action);
          mismatches++;
        end
      end
      if ($urandom_range(0, 15) == 0) rx_paced = !rx_paced;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("icmp_echo_packet_filter_top_tb NOT OK");
    $finish;
  end

endmodule
